// ===== sv/sbs_pkg.sv =====
// Shared types, constants and tables for the spectral band statistics block.
package sbs_pkg;

  localparam int NUM_BINS      = 9;
  localparam int NUM_BANDS     = 5;
  localparam int ADDR_W        = 4;
  localparam int BAND_W        = 3;
  localparam int STEP_W        = 6;
  localparam int CORDIC_STEPS  = 14;
  localparam int PHASE_W       = 16;
  localparam int PHASE_SUM_W   = 18;
  localparam int ENERGY_OUT_W  = 33;
  localparam int MAG_OUT_W     = 17;
  localparam int TOTAL_OUT_W   = 35;
  localparam int OUT_DATA_W    = 112;

  localparam logic [ADDR_W-1:0]  LAST_BIN  = ADDR_W'(NUM_BINS - 1);
  localparam logic [BAND_W-1:0]  LAST_BAND = BAND_W'(NUM_BANDS - 1);
  localparam logic signed [PHASE_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [PHASE_W-1:0] HALF_PI_Q13 = 16'sd12868;
  // Reciprocal of three in 17 fractional bits, exact below 2^17.
  localparam logic [15:0] RECIP3_Q17 = 16'd43691;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_START,
    OP_LOAD,
    OP_SQ_RE,
    OP_SQ_IM,
    OP_ROT,
    OP_CORDIC,
    OP_ACC,
    OP_MEAN,
    OP_SQRT,
    OP_EMIT
  } sbs_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LOAD,
    S_SQ_RE,
    S_SQ_IM,
    S_ROT,
    S_CORDIC,
    S_ACC,
    S_MEAN,
    S_SQRT,
    S_EMIT
  } sbs_state_t;

  typedef struct packed {
    sbs_op_t            op;
    logic [ADDR_W-1:0]  addr;
    logic [BAND_W-1:0]  band;
    logic [STEP_W-1:0]  step;
  } sbs_cmd_t;

  typedef struct packed {
    logic nonzero;
    logic out_busy;
  } sbs_stat_t;

  // Index of the highest bin of each band.
  function automatic logic [ADDR_W-1:0] band_last(input logic [BAND_W-1:0] band);
    logic [ADDR_W-1:0] r;
    case (band)
      3'd0:    r = 4'd2;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd6;
      3'd3:    r = 4'd7;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  // round(atan(2^-i) * 8192)
  function automatic logic signed [PHASE_W-1:0] atan_q13(input logic [3:0] i);
    logic signed [PHASE_W-1:0] r;
    case (i)
      4'd0:    r = 16'sd6434;
      4'd1:    r = 16'sd3798;
      4'd2:    r = 16'sd2007;
      4'd3:    r = 16'sd1019;
      4'd4:    r = 16'sd511;
      4'd5:    r = 16'sd256;
      4'd6:    r = 16'sd128;
      4'd7:    r = 16'sd64;
      4'd8:    r = 16'sd32;
      4'd9:    r = 16'sd16;
      4'd10:   r = 16'sd8;
      4'd11:   r = 16'sd4;
      4'd12:   r = 16'sd2;
      4'd13:   r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sbs_ctrl.sv =====
// Controller state machine that sequences bin capture and per-band statistics.
module sbs_ctrl import sbs_pkg::*; #(
  parameter int SQRT_STEPS = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_first,
  output logic      in_ready,
  input  sbs_stat_t stat,
  output sbs_cmd_t  cmd
);

  sbs_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] bin_cnt_r, bin_cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] wr_idx;
  logic              band_end;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bin_cnt_r <= '0;
      addr_r    <= '0;
      band_r    <= '0;
      step_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      bin_cnt_r <= bin_cnt_nxt;
      addr_r    <= addr_nxt;
      band_r    <= band_nxt;
      step_r    <= step_nxt;
    end
  end

  assign wr_idx   = in_first ? '0 : bin_cnt_r;
  assign band_end = (addr_r == band_last(band_r));

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    bin_cnt_nxt = bin_cnt_r;
    addr_nxt    = addr_r;
    band_nxt    = band_r;
    step_nxt    = step_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.addr    = addr_r;
    cmd.band    = band_r;
    cmd.step    = step_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.addr = wr_idx;
        if (in_valid) begin
          cmd.op = OP_STORE;
          if (wr_idx == LAST_BIN) begin
            bin_cnt_nxt = '0;
            state_nxt   = S_START;
          end else begin
            bin_cnt_nxt = wr_idx + 1'b1;
          end
        end
      end
      S_START: begin
        cmd.op    = OP_START;
        addr_nxt  = '0;
        band_nxt  = '0;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_SQ_RE;
      end
      S_SQ_RE: begin
        cmd.op    = OP_SQ_RE;
        state_nxt = S_SQ_IM;
      end
      S_SQ_IM: begin
        cmd.op    = OP_SQ_IM;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op   = OP_ROT;
        step_nxt = '0;
        if (stat.nonzero) begin
          state_nxt = S_CORDIC;
        end else if (band_end) begin
          state_nxt = S_MEAN;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_CORDIC: begin
        cmd.op   = OP_CORDIC;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (band_end) begin
          state_nxt = S_MEAN;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_MEAN: begin
        cmd.op    = OP_MEAN;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op = OP_EMIT;
          if (band_r == LAST_BAND) begin
            state_nxt = S_IDLE;
          end else begin
            band_nxt  = band_r + 1'b1;
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sbs_dp.sv =====
// Datapath: bin store, shared squarer, CORDIC phase unit, mean, square root and result register.
module sbs_dp import sbs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ENERGY_W     = 34
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbs_cmd_t                       cmd,
  output sbs_stat_t                      stat,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [OUT_DATA_W-1:0]          out_data,
  output logic                           out_last
);

  localparam int CW      = SAMPLE_WIDTH + 3;
  localparam int PW      = 2 * SAMPLE_WIDTH;
  localparam int ROOT_W  = ENERGY_W / 2;
  localparam int REM_W   = ROOT_W + 2;

  // Bin store, written while idle and read one entry per bin during a frame.
  logic signed [SAMPLE_WIDTH-1:0] store_re [NUM_BINS];
  logic signed [SAMPLE_WIDTH-1:0] store_im [NUM_BINS];

  logic signed [SAMPLE_WIDTH-1:0] re_r, im_r;
  logic signed [PW-1:0]           prod_r;
  logic [ENERGY_W-1:0]            energy_r;
  logic signed [CW-1:0]           cx_r, cy_r;
  logic signed [PHASE_W-1:0]      cz_r;
  logic signed [PHASE_SUM_W-1:0]  psum_r;
  logic [1:0]                     pcnt_r;
  logic signed [PHASE_W-1:0]      mean_r;
  logic [TOTAL_OUT_W-1:0]         total_r;
  logic [ENERGY_W-1:0]            best_e_r;
  logic [BAND_W-1:0]              best_r;
  logic [ENERGY_W-1:0]            rad_r;
  logic [REM_W-1:0]               rem_r;
  logic [ROOT_W-1:0]              root_r;
  logic                           out_valid_r;
  logic [OUT_DATA_W-1:0]          out_data_r;
  logic                           out_last_r;

  logic signed [CW-1:0]           xs, ys;
  logic signed [PHASE_W-1:0]      z_sat;
  logic [PHASE_SUM_W-1:0]         abs_sum;
  logic [PHASE_SUM_W-1:0]         quot;
  logic [PHASE_SUM_W+15:0]        prod3;
  logic signed [PHASE_SUM_W-1:0]  mean_full;
  logic [REM_W-1:0]               rem_sh, trial;
  logic [63:0]                    energy64, root64;
  logic                           is_last_band;

  assign stat.nonzero  = (re_r != '0) || (im_r != '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  // CORDIC shifted terms; arithmetic shift is a floor shift.
  assign xs = cx_r >>> cmd.step[3:0];
  assign ys = cy_r >>> cmd.step[3:0];

  // Saturation of the final angle to plus or minus pi.
  always_comb begin
    if (cz_r > PI_Q13) begin
      z_sat = PI_Q13;
    end else if (cz_r < -PI_Q13) begin
      z_sat = -PI_Q13;
    end else begin
      z_sat = cz_r;
    end
  end

  // Rounded mean over one to three bins, ties away from zero.
  always_comb begin
    abs_sum = psum_r[PHASE_SUM_W-1] ? PHASE_SUM_W'(-psum_r) : PHASE_SUM_W'(psum_r);
    prod3   = (PHASE_SUM_W + 16)'(abs_sum + 1'b1) * (PHASE_SUM_W + 16)'(RECIP3_Q17);
    case (pcnt_r)
      2'd1:    quot = abs_sum;
      2'd2:    quot = (abs_sum + 1'b1) >> 1;
      2'd3:    quot = PHASE_SUM_W'(prod3 >> 17);
      default: quot = '0;
    endcase
    mean_full = psum_r[PHASE_SUM_W-1] ? -$signed(quot) : $signed(quot);
  end

  // One two-bit step of the restoring square root.
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[ENERGY_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  assign energy64     = 64'(energy_r);
  assign root64       = 64'(root_r);
  assign is_last_band = (cmd.band == LAST_BAND);

  // Store writes and reads.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) begin
      store_re[cmd.addr] <= in_re;
      store_im[cmd.addr] <= in_im;
    end
    if (cmd.op == OP_LOAD) begin
      re_r <= store_re[cmd.addr];
      im_r <= store_im[cmd.addr];
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        energy_r <= '0;
        psum_r   <= '0;
        pcnt_r   <= '0;
        total_r  <= '0;
        best_e_r <= '0;
        best_r   <= '0;
      end
      OP_SQ_RE: begin
        prod_r <= re_r * re_r;
      end
      OP_SQ_IM: begin
        energy_r <= energy_r + ENERGY_W'(unsigned'(prod_r));
        prod_r   <= im_r * im_r;
      end
      OP_ROT: begin
        energy_r <= energy_r + ENERGY_W'(unsigned'(prod_r));
        if (re_r < 0) begin
          if (im_r >= 0) begin
            cx_r <= CW'(im_r);
            cy_r <= -CW'(re_r);
            cz_r <= HALF_PI_Q13;
          end else begin
            cx_r <= -CW'(im_r);
            cy_r <= CW'(re_r);
            cz_r <= -HALF_PI_Q13;
          end
        end else begin
          cx_r <= CW'(re_r);
          cy_r <= CW'(im_r);
          cz_r <= '0;
        end
      end
      OP_CORDIC: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_q13(cmd.step[3:0]);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_q13(cmd.step[3:0]);
        end
      end
      OP_ACC: begin
        psum_r <= psum_r + PHASE_SUM_W'(z_sat);
        pcnt_r <= pcnt_r + 1'b1;
      end
      OP_MEAN: begin
        mean_r  <= PHASE_W'(mean_full);
        total_r <= total_r + TOTAL_OUT_W'(energy64);
        if (energy_r > best_e_r) begin
          best_e_r <= energy_r;
          best_r   <= cmd.band;
        end
        rad_r  <= energy_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQRT: begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      OP_EMIT: begin
        energy_r <= '0;
        psum_r   <= '0;
        pcnt_r   <= '0;
      end
      default: begin
      end
    endcase
  end

  // Result register; a transfer clears the valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_last_r <= is_last_band;
      out_data_r <= {5'b0,
                     is_last_band ? best_r : 3'b0,
                     is_last_band ? total_r : {TOTAL_OUT_W{1'b0}},
                     mean_r,
                     root64[MAG_OUT_W-1:0],
                     energy64[ENERGY_OUT_W-1:0],
                     cmd.band};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/spectral_band_statistics.sv =====
// Top level of the spectral band statistics block.
// Bins stream in one per transfer, one per cycle while the block is idle. On the
// ninth bin the block stops taking input and walks the five bands: each bin takes
// a store read, two squarings on one shared multiplier and a pre-rotation, plus,
// when it is nonzero, 14 CORDIC iterations and the phase sum; each band then takes
// the mean, the 2-bit-per-cycle square root and the load of the result register,
// which waits while the previous result has not been taken. Input is taken again
// as soon as the fifth result sits in the output register.
module spectral_band_statistics import sbs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bin_real, bin_imag
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // first_bin
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // band_index, energy, magnitude, phase_mean, total, dominant
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int ENERGY_W = (2 * SAMPLE_WIDTH + 2 > 64) ? 64 : 2 * SAMPLE_WIDTH + 2;

  sbs_cmd_t  cmd;
  sbs_stat_t stat;

  sbs_ctrl #(
    .SQRT_STEPS (ENERGY_W / 2)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_first (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbs_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ENERGY_W     (ENERGY_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_re     (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_im     (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
